// File: src/kmp_pkg.sv
// Shared types and constants for the KMP substring search core.
// Holds opcodes, the default pattern depth and the store control word.
// No dependencies.
package kmp_pkg;

	localparam int MAX_PATTERN_DEF = 256;
	localparam int SYM_W           = 8;
	localparam int POS_W           = 32;

	typedef logic [1:0] op_t;

	localparam op_t OP_RESTART = 2'd0;
	localparam op_t OP_APPEND  = 2'd1;
	localparam op_t OP_TEXT    = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// File: src/kmp_store.sv
// Pattern byte store and failure link store, one write and one read port each.
// Links are kept as value plus one, so zero stands for the end of the chain.
// Depends on kmp_pkg.
module kmp_store #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
	localparam int IW = $clog2(MAX_PATTERN)
) (
	input  logic                     clk,
	input  kmp_pkg::mem_ctl_t        ctl,
	input  logic [IW-1:0]            rd_addr,
	input  logic [IW-1:0]            wr_addr,
	input  logic [kmp_pkg::SYM_W-1:0] wr_sym,
	input  logic [IW-1:0]            wr_link,
	output logic [kmp_pkg::SYM_W-1:0] rd_sym,
	output logic [IW-1:0]            rd_link
);
	import kmp_pkg::*;

	logic [SYM_W-1:0] sym_mem [MAX_PATTERN];
	logic [IW-1:0]    link_mem [MAX_PATTERN];
	logic [SYM_W-1:0] rd_sym_q;
	logic [IW-1:0]    rd_link_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			sym_mem[wr_addr]  <= wr_sym;
			link_mem[wr_addr] <= wr_link;
		end
		if (ctl.rd_en) begin
			rd_sym_q  <= sym_mem[rd_addr];
			rd_link_q <= link_mem[rd_addr];
		end
	end

	assign rd_sym  = rd_sym_q;
	assign rd_link = rd_link_q;

endmodule

// File: src/kmp_substring_search_core.sv
// Top level of the KMP first-occurrence search: sequencer, byte comparator
// and search state around the pattern/link store.
// Depends on kmp_pkg and kmp_store.
//
// channel   dir  handshake            ports
// command   in   start && !busy       opcode, symbol, last_text
// result    out  done, one cycle      found, match_start, no_match, pattern_full
//
// Restart, unused opcode, full append, first append, text after a match and text
// with an empty pattern: done in the cycle after accept.
// Append: S_PREV, f compares in S_CMP, S_FIN; text word: f compares in S_CMP,
// S_FIN; f = byte compares on the link chain (none for the second append, at
// least one otherwise), one compare per cycle through the single store read port.
// busy is high from accept until the cycle before done; the next word may be
// offered while done is high. Reset clears the pattern and search state at once.
// The receiver cannot stall; done, no_match and pattern_full show for one cycle.
module kmp_substring_search_core #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  kmp_pkg::op_t              opcode,
	input  logic [kmp_pkg::SYM_W-1:0] symbol,
	input  logic                      last_text,
	output logic                      done,
	output logic                      found,
	output logic [kmp_pkg::POS_W-1:0] match_start,
	output logic                      no_match,
	output logic                      pattern_full
);
	import kmp_pkg::*;

	localparam int IW = $clog2(MAX_PATTERN);
	localparam int LW = $clog2(MAX_PATTERN + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREV = 4'b0010,
		S_CMP  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [LW-1:0]    len_q;
	logic [IW-1:0]    bpp_q;
	logic [IW-1:0]    ms_q;
	logic [POS_W-1:0] tpos_q;
	logic             found_q;
	logic [POS_W-1:0] mpos_q;
	logic             done_q;
	logic             miss_q;
	logic             full_q;
	logic             build_q;
	logic             last_q;
	logic [SYM_W-1:0] sym_q;
	logic [SYM_W-1:0] tgt_q;
	logic [IW-1:0]    cur_q;
	logic [LW-1:0]    kp1_q;

	mem_ctl_t         mem_ctl;
	logic [IW-1:0]    rd_addr;
	logic [IW-1:0]    wr_addr;
	logic [SYM_W-1:0] wr_sym;
	logic [IW-1:0]    wr_link;
	logic [SYM_W-1:0] rd_sym;
	logic [IW-1:0]    rd_link;

	logic             len_full;
	logic [LW-1:0]    len_m1;
	logic [LW-1:0]    kp1_inc;
	logic [POS_W-1:0] tpos_inc;
	logic             sym_hit;

	assign len_full = (len_q == LW'(MAX_PATTERN));
	assign len_m1   = len_q - LW'(1);
	assign kp1_inc  = kp1_q + LW'(1);
	assign tpos_inc = (tpos_q == '1) ? tpos_q : tpos_q + POS_W'(1);
	assign sym_hit  = (rd_sym == tgt_q);

	kmp_store #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_sym  (wr_sym),
		.wr_link (wr_link),
		.rd_sym  (rd_sym),
		.rd_link (rd_link)
	);

	always_comb begin
		mem_ctl = '0;
		rd_addr = cur_q;
		wr_addr = len_q[IW-1:0];
		wr_sym  = sym_q;
		wr_link = kp1_inc[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (opcode)
						OP_APPEND: begin
							if (!len_full) begin
								if (len_q == '0) begin
									mem_ctl.wr_en = 1'b1;
									wr_addr       = '0;
									wr_sym        = symbol;
									wr_link       = '0;
								end else begin
									mem_ctl.rd_en = 1'b1;
									rd_addr       = len_m1[IW-1:0];
								end
							end
						end
						OP_TEXT: begin
							if (!found_q && len_q != '0) begin
								mem_ctl.rd_en = 1'b1;
								rd_addr       = ms_q;
							end
						end
						default: ;
					endcase
				end
			end
			S_PREV: begin
				if (bpp_q != '0) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = bpp_q - IW'(1);
				end
			end
			S_CMP: begin
				if (!sym_hit && rd_link != '0) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = rd_link - IW'(1);
				end
			end
			S_FIN: begin
				mem_ctl.wr_en = build_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			bpp_q   <= '0;
			ms_q    <= '0;
			tpos_q  <= '0;
			found_q <= 1'b0;
			mpos_q  <= '0;
			done_q  <= 1'b0;
			miss_q  <= 1'b0;
			full_q  <= 1'b0;
			build_q <= 1'b0;
			last_q  <= 1'b0;
			sym_q   <= '0;
			tgt_q   <= '0;
			cur_q   <= '0;
			kp1_q   <= '0;
		end else begin
			done_q <= 1'b0;
			miss_q <= 1'b0;
			full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						build_q <= (opcode == OP_APPEND);
						last_q  <= last_text;
						sym_q   <= symbol;
						tgt_q   <= symbol;
						cur_q   <= ms_q;
						case (opcode)
							OP_RESTART: begin
								len_q   <= '0;
								bpp_q   <= '0;
								ms_q    <= '0;
								tpos_q  <= '0;
								found_q <= 1'b0;
								mpos_q  <= '0;
								done_q  <= 1'b1;
							end
							OP_APPEND: begin
								if (len_full) begin
									full_q <= 1'b1;
									done_q <= 1'b1;
								end else if (len_q == '0) begin
									len_q  <= LW'(1);
									bpp_q  <= '0;
									done_q <= 1'b1;
								end else begin
									state_q <= S_PREV;
								end
							end
							OP_TEXT: begin
								if (found_q) begin
									done_q <= 1'b1;
								end else if (len_q == '0) begin
									found_q <= 1'b1;
									mpos_q  <= '0;
									done_q  <= 1'b1;
								end else begin
									state_q <= S_CMP;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_PREV: begin
					tgt_q <= rd_sym;
					if (bpp_q == '0) begin
						kp1_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cur_q   <= bpp_q - IW'(1);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (sym_hit) begin
						kp1_q   <= LW'(cur_q) + LW'(1);
						state_q <= S_FIN;
					end else if (rd_link == '0) begin
						kp1_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cur_q <= rd_link - IW'(1);
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (build_q) begin
						len_q <= len_q + LW'(1);
						bpp_q <= kp1_inc[IW-1:0];
					end else if (kp1_q == len_q) begin
						found_q <= 1'b1;
						mpos_q  <= tpos_inc - POS_W'(len_q);
						tpos_q  <= tpos_inc;
					end else if (last_q) begin
						ms_q   <= '0;
						tpos_q <= '0;
						miss_q <= 1'b1;
					end else begin
						ms_q   <= kp1_q[IW-1:0];
						tpos_q <= tpos_inc;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign found        = found_q;
	assign match_start  = found_q ? mpos_q : '0;
	assign no_match     = miss_q;
	assign pattern_full = full_q;

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("done without a preceding word");

	a_miss_excludes_found: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(no_match && found))
		else $error("no_match raised together with found");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PATTERN))
		else $error("pattern length beyond store depth");

	a_cmp_index_in_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (LW'(cur_q) < len_q))
		else $error("compare index outside the stored pattern");

	a_full_only_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_full |-> (len_q == LW'(MAX_PATTERN)))
		else $error("append dropped below full depth");

endmodule
